[rtl/core/pcpu_pkg.sv]
// Shared types and constants for the polar converter with phase unwrap.
// Holds the sequencer state type, unit status struct and CORDIC angle table.
// Used by pcpu_cordic, pcpu_isqrt and polar_convert_phase_unwrap.
`default_nettype none

package pcpu_pkg;

  localparam int CH_W         = 3;
  localparam int PHASE_W      = 17;
  localparam int DIFF_W       = 18;
  localparam int ACC_W        = 48;
  localparam int Z_W          = 26;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIFF,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] step);
    logic signed [Z_W-1:0] val;
    case (step)
      5'd0:    val = 26'sd4194304;
      5'd1:    val = 26'sd2476042;
      5'd2:    val = 26'sd1308273;
      5'd3:    val = 26'sd664100;
      5'd4:    val = 26'sd333339;
      5'd5:    val = 26'sd166832;
      5'd6:    val = 26'sd83436;
      5'd7:    val = 26'sd41721;
      5'd8:    val = 26'sd20861;
      5'd9:    val = 26'sd10430;
      5'd10:   val = 26'sd5215;
      5'd11:   val = 26'sd2608;
      5'd12:   val = 26'sd1304;
      5'd13:   val = 26'sd652;
      5'd14:   val = 26'sd326;
      5'd15:   val = 26'sd163;
      5'd16:   val = 26'sd81;
      5'd17:   val = 26'sd41;
      5'd18:   val = 26'sd20;
      5'd19:   val = 26'sd10;
      5'd20:   val = 26'sd5;
      5'd21:   val = 26'sd3;
      5'd22:   val = 26'sd1;
      5'd23:   val = 26'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pcpu_cordic.sv]
// Iterative vectoring CORDIC: one shared add/subtract step per cycle.
// Produces the phase of im/re, clamped to [-pi/2, pi/2], in units of pi/65536; uses pcpu_pkg.
`default_nettype none

module pcpu_cordic #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic signed [SAMPLE_BITS-1:0]         re,
  input  wire logic signed [SAMPLE_BITS-1:0]         im,
  output pcpu_pkg::unit_stat_t                       stat,
  output logic signed [pcpu_pkg::PHASE_W-1:0]        phase
);

  localparam int XW = SAMPLE_BITS + 26;
  localparam int ZW = pcpu_pkg::Z_W;
  localparam int PW = pcpu_pkg::PHASE_W;
  localparam logic [pcpu_pkg::STEP_W-1:0] LAST_STEP =
    pcpu_pkg::STEP_W'(pcpu_pkg::CORDIC_STEPS - 1);
  localparam logic signed [ZW-1:0] RND    = ZW'(128);
  localparam logic signed [ZW-1:0] PH_MAX = ZW'(32768);
  localparam logic signed [ZW-1:0] PH_MIN = -ZW'(32768);

  logic                             iter_r;
  logic                             rnd_r;
  logic                             done_r;
  logic [pcpu_pkg::STEP_W-1:0]      cnt_r;
  logic signed [XW-1:0]             x_r;
  logic signed [XW-1:0]             y_r;
  logic signed [ZW-1:0]             z_r;
  logic                             zero_r;
  logic                             im_pos_r;
  logic                             im_neg_r;
  logic signed [PW-1:0]             phase_r;

  logic signed [XW-1:0]             re_ext;
  logic signed [XW-1:0]             im_ext;
  logic signed [XW-1:0]             xs;
  logic signed [XW-1:0]             ys;
  logic signed [ZW-1:0]             ang;
  logic signed [ZW-1:0]             zr;
  logic signed [ZW-1:0]             zq;

  always_comb begin
    re_ext = XW'(re);
    im_ext = XW'(im);
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    ang    = pcpu_pkg::atan_entry(cnt_r);
    zr     = z_r + RND;
    zq     = zr >>> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= rnd_r;
      rnd_r  <= iter_r && (cnt_r == LAST_STEP);
      if (start) begin
        iter_r <= 1'b1;
        cnt_r  <= '0;
      end else if (iter_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          iter_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r      <= (re < 0) ? ((-re_ext) <<< 24) : (re_ext <<< 24);
      y_r      <= (re < 0) ? ((-im_ext) <<< 24) : (im_ext <<< 24);
      z_r      <= '0;
      zero_r   <= (re == '0);
      im_pos_r <= (im > 0);
      im_neg_r <= (im < 0);
    end else if (iter_r) begin
      if (!y_r[XW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end
    end
    if (rnd_r) begin
      if (zero_r) begin
        phase_r <= im_pos_r ? PW'(PH_MAX) : (im_neg_r ? PW'(PH_MIN) : '0);
      end else if (zq > PH_MAX) begin
        phase_r <= PW'(PH_MAX);
      end else if (zq < PH_MIN) begin
        phase_r <= PW'(PH_MIN);
      end else begin
        phase_r <= PW'(zq);
      end
    end
  end

  assign stat.busy = iter_r | rnd_r;
  assign stat.done = done_r;
  assign phase     = phase_r;

endmodule

`default_nettype wire

[rtl/core/pcpu_isqrt.sv]
// Iterative rounded square root of re^2 + im^2, one result bit per cycle.
// Squares are registered before the recurrence; uses pcpu_pkg.
`default_nettype none

module pcpu_isqrt #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [SAMPLE_BITS-1:0] re,
  input  wire logic signed [SAMPLE_BITS-1:0] im,
  output pcpu_pkg::unit_stat_t               stat,
  output logic [SAMPLE_BITS-1:0]             magnitude
);

  localparam int NW    = 2 * SAMPLE_BITS;
  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_BITS - 1);

  logic                    sum_r;
  logic                    iter_r;
  logic                    fin_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [NW-1:0]           sqa_r;
  logic [NW-1:0]           sqb_r;
  logic [NW-1:0]           rem_r;
  logic [NW-1:0]           res_r;
  logic [NW-1:0]           bit_r;
  logic [SAMPLE_BITS-1:0]  mag_r;

  logic signed [NW-1:0]    pa;
  logic signed [NW-1:0]    pb;
  logic [NW-1:0]           trial;
  logic [NW-1:0]           res_rnd;

  always_comb begin
    pa      = re * re;
    pb      = im * im;
    trial   = res_r + bit_r;
    res_rnd = res_r + NW'(rem_r > res_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= 1'b0;
      iter_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= iter_r && (cnt_r == LAST_CNT);
      sum_r  <= start;
      if (sum_r) begin
        iter_r <= 1'b1;
        cnt_r  <= '0;
      end else if (iter_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          iter_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sqa_r <= $unsigned(pa);
      sqb_r <= $unsigned(pb);
    end
    if (sum_r) begin
      rem_r <= sqa_r + sqb_r;
      res_r <= '0;
      bit_r <= NW'(1) << (NW - 2);
    end else if (iter_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (fin_r) begin
      mag_r <= res_rnd[SAMPLE_BITS-1:0];
    end
  end

  assign stat.busy = sum_r | iter_r | fin_r;
  assign stat.done = done_r;
  assign magnitude = mag_r;

endmodule

`default_nettype wire

[rtl/core/polar_convert_phase_unwrap.sv]
// Rectangular-to-polar converter with per-channel phase unwrapping, built on
// pcpu_pkg, pcpu_cordic and pcpu_isqrt. Each request carries one complex sample
// of a channel and yields one result: the rounded magnitude and a saturating
// 48-bit unwrapped phase in units of pi/65536. The block works on one request
// at a time and holds in_stall high until the sample has been processed; a
// finished result waits in the output register while the next request is taken.
// The one-bit-per-cycle square-root recurrence runs alongside the 24-step
// CORDIC loop; the difference and accumulate steps follow once both finish.
// Channel numbers at or above CHANNELS use the state of channel modulo
// CHANNELS, while out_channel_out echoes the request's channel.
`default_nettype none

module polar_convert_phase_unwrap #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [pcpu_pkg::CH_W-1:0]          in_channel,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_real_part,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_imag_part,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [pcpu_pkg::CH_W-1:0]               out_channel_out,
  output logic [SAMPLE_BITS-1:0]                  out_magnitude,
  output logic signed [pcpu_pkg::ACC_W-1:0]       out_unwrapped_phase
);

  localparam int CH_W    = pcpu_pkg::CH_W;
  localparam int PW      = pcpu_pkg::PHASE_W;
  localparam int DW      = pcpu_pkg::DIFF_W;
  localparam int AW      = pcpu_pkg::ACC_W;
  localparam int DEPTH   = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [DW-1:0] D_HI = DW'(32768);
  localparam logic signed [DW-1:0] D_LO = -DW'(32768);
  localparam logic signed [DW-1:0] TURN = DW'(65536);
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  pcpu_pkg::state_t        state_r;
  pcpu_pkg::state_t        state_nxt;
  pcpu_pkg::unit_stat_t    cst;
  pcpu_pkg::unit_stat_t    sst;

  logic                    accept;
  logic                    out_load;
  logic [IDX_W-1:0]        idx_in;
  logic [IDX_W-1:0]        idx_r;
  logic [CH_W-1:0]         ch_r;
  logic signed [PW-1:0]    cord_phase;
  logic [SAMPLE_BITS-1:0]  sqrt_mag;
  logic signed [DW-1:0]    d_raw;
  logic signed [DW-1:0]    d_fold;
  logic signed [DW-1:0]    d_r;
  logic signed [AW:0]      acc_sum;
  logic signed [AW-1:0]    acc_sat;
  logic signed [AW-1:0]    acc_new;

  logic [DEPTH-1:0]        seen_r;
  logic signed [PW-1:0]    prev_r [DEPTH];
  logic signed [AW-1:0]    acc_r  [DEPTH];

  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic [SAMPLE_BITS-1:0]  out_mag_r;
  logic signed [AW-1:0]    out_ph_r;

  assign accept = in_valid && !in_stall;

  always_comb begin
    idx_in = '0;
    for (int c = 0; c < (1 << CH_W); c++) begin
      if (in_channel == CH_W'(c)) begin
        idx_in = IDX_W'(c % CHANNELS);
      end
    end
  end

  pcpu_cordic #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .re    (in_real_part),
    .im    (in_imag_part),
    .stat  (cst),
    .phase (cord_phase)
  );

  pcpu_isqrt #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .re        (in_real_part),
    .im        (in_imag_part),
    .stat      (sst),
    .magnitude (sqrt_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcpu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      pcpu_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pcpu_pkg::ST_CALC;
        end
      end
      pcpu_pkg::ST_CALC: begin
        if (!cst.busy && !sst.busy) begin
          state_nxt = pcpu_pkg::ST_DIFF;
        end
      end
      pcpu_pkg::ST_DIFF: begin
        state_nxt = pcpu_pkg::ST_ACC;
      end
      pcpu_pkg::ST_ACC: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = pcpu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcpu_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != pcpu_pkg::ST_IDLE);

  always_comb begin
    d_raw = DW'(cord_phase) - DW'(prev_r[idx_r]);
    if (d_raw < D_LO) begin
      d_fold = d_raw + TURN;
    end else if (d_raw > D_HI) begin
      d_fold = d_raw - TURN;
    end else begin
      d_fold = d_raw;
    end
    acc_sum = (AW+1)'(acc_r[idx_r]) + (AW+1)'(d_r);
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      acc_sat = acc_sum[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[AW-1:0];
    end
    acc_new = seen_r[idx_r] ? acc_sat : AW'(cord_phase);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        seen_r[idx_r] <= 1'b1;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r  <= in_channel;
      idx_r <= idx_in;
    end
    if (state_r == pcpu_pkg::ST_DIFF) begin
      d_r <= d_fold;
    end
    if (out_load) begin
      prev_r[idx_r] <= cord_phase;
      acc_r[idx_r]  <= acc_new;
      out_ch_r      <= ch_r;
      out_mag_r     <= sqrt_mag;
      out_ph_r      <= acc_new;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel_out     = out_ch_r;
  assign out_magnitude       = out_mag_r;
  assign out_unwrapped_phase = out_ph_r;

  a_cordic_done_in_calc : assert property (@(posedge clk) disable iff (!rst_n)
    cst.done |-> (state_r == pcpu_pkg::ST_CALC))
    else $error("CORDIC finished outside the calculation state.");

  a_sqrt_done_in_calc : assert property (@(posedge clk) disable iff (!rst_n)
    sst.done |-> (state_r == pcpu_pkg::ST_CALC))
    else $error("Square root finished outside the calculation state.");

  a_units_idle_in_diff : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcpu_pkg::ST_DIFF) |-> (!cst.busy && !sst.busy))
    else $error("Arithmetic unit still busy when the phase difference is taken.");

  a_result_presented : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == pcpu_pkg::ST_ACC) && (!out_valid_r || !out_stall)) |=> out_valid)
    else $error("Finished request did not reach the output register.");

endmodule

`default_nettype wire
